/* sv/text_console_writer_assert.svh */
// Assertion macros for the text console writer checker.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define TCW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/tcw_pkg.sv */
// Shared constants, types and codes of the text console writer.
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;
  localparam int ADDR_W  = $clog2(CELLS);

  localparam int FUNC_W  = 2;
  localparam int CHAR_W  = 8;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int CELL_W  = 16;
  localparam int COLOR_W = 8;

  localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h0F;
  localparam logic [CHAR_W-1:0]  BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0]  NEWLINE_CHAR = 8'h0A;

  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  localparam logic REG_TEXT_COLOR = 1'b0;

  localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] COPY_LAST  = ADDR_W'(CELLS - COLUMNS - 1);
  localparam logic [ADDR_W-1:0] FILL_FIRST = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_DRAIN,
    ST_FILL
  } state_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [COL_W-1:0]  cell_col;
    logic [ROW_W-1:0]  cell_row;
    logic [CHAR_W-1:0] char_code;
  } cmd_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [CELL_W-1:0] cell_value;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

`default_nettype wire

/* sv/text_console_writer.sv */
// Top level of the text console writer: ports, colour register, result beat.
//
//   channel   dir  payload (low bit up)                                   size
//   s_axis    in   tdata: char_code, cell_row, cell_col; tuser: func      24+2
//   m_axis    out  tdata: cell_value, cursor_row, cursor_col              32
//   apb       in   text_color at byte address 0                           32
//
// Put character or newline: written from idle; read: via ST_READ; clear: every
// cell blanked in ST_FILL. A put that moves past the last row scrolls, set by
// the single write port of the screen store (copy, then blank the bottom row).
// After reset a clearing pass writes every cell; no beat is taken meanwhile,
// configuration writes are. Input is taken only when idle and the result
// register is free or being emptied; a stalled result is held.
`default_nettype none

module text_console_writer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // char_code[7:0], cell_row[12:8], cell_col[19:13]
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // cell_value[15:0], cursor_row[20:16], cursor_col[27:21]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import tcw_pkg::*;

  logic [COLOR_W-1:0] text_color;
  cmd_t               cmd;
  logic               out_free;
  logic               res_load;
  result_t            res;
  result_t            out_res;
  ram_req_t           ram;
  logic [CELL_W-1:0]  rdata;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_TEXT_COLOR);
  assign prdata    = (paddr[2] == REG_TEXT_COLOR) ? {24'b0, text_color} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= RESET_COLOR;
    end else if (cfg_write) begin
      text_color <= pwdata[COLOR_W-1:0];
    end
  end

  assign cmd      = {s_axis_tuser, s_axis_tdata[19:0]};
  assign out_free = !m_axis_tvalid || m_axis_tready;

  tcw_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .text_color (text_color),
    .cmd        (cmd),
    .cmd_valid  (s_axis_tvalid),
    .cmd_ready  (s_axis_tready),
    .out_free   (out_free),
    .res_load   (res_load),
    .res        (res),
    .ram        (ram),
    .rdata      (rdata)
  );

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram.we),
    .waddr (ram.waddr),
    .wdata (ram.wdata),
    .re    (ram.re),
    .raddr (ram.raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {4'b0, out_res};

endmodule

`default_nettype wire

/* sv/tcw_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* sv/tcw_seq.sv */
// Sequencer: cursor, address counter and screen store sweeps.
`default_nettype none

module tcw_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [tcw_pkg::COLOR_W-1:0]   text_color,
  input  tcw_pkg::cmd_t                 cmd,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  logic                          out_free,
  output logic                          res_load,
  output tcw_pkg::result_t              res,
  output tcw_pkg::ram_req_t             ram,
  input  logic [tcw_pkg::CELL_W-1:0]    rdata
);

  import tcw_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [ADDR_W-1:0] ptr;
  logic [ADDR_W-1:0] ptr_next;
  logic [ADDR_W-1:0] hold_addr;
  logic              pend;
  logic [ROW_W-1:0]  cur_row;
  logic [ROW_W-1:0]  cur_row_next;
  logic [COL_W-1:0]  cur_col;
  logic [COL_W-1:0]  cur_col_next;

  logic              accept;
  logic              newline;
  logic              wrap;
  logic              scroll;
  logic              read_ok;
  logic [COL_W:0]    col_inc;
  logic [ROW_W:0]    row_inc;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] read_addr;
  logic [CELL_W-1:0] put_word;
  logic [CELL_W-1:0] blank_word;

  assign accept     = cmd_valid && cmd_ready;
  assign newline    = (cmd.char_code == NEWLINE_CHAR);
  assign col_inc    = (COL_W+1)'(cur_col) + (COL_W+1)'(1);
  assign row_inc    = (ROW_W+1)'(cur_row) + (ROW_W+1)'(1);
  assign wrap       = newline || (int'(col_inc) >= COLUMNS);
  assign scroll     = wrap && (int'(row_inc) >= ROWS);
  assign read_ok    = (int'(cmd.cell_row) < ROWS) && (int'(cmd.cell_col) < COLUMNS);
  assign cur_addr   = ADDR_W'(cur_row) * ROW_STRIDE + ADDR_W'(cur_col);
  assign read_addr  = ADDR_W'(cmd.cell_row) * ROW_STRIDE + ADDR_W'(cmd.cell_col);
  assign put_word   = {text_color, cmd.char_code};
  assign blank_word = {text_color, BLANK_CHAR};

  always_comb begin
    cur_row_next = cur_row;
    cur_col_next = cur_col;
    if (accept && (cmd.func == FUNC_PUT)) begin
      if (wrap) begin
        cur_col_next = '0;
        cur_row_next = scroll ? ROW_W'(ROWS - 1) : row_inc[ROW_W-1:0];
      end else begin
        cur_col_next = col_inc[COL_W-1:0];
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (ptr == LAST_CELL) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if ((cmd.func == FUNC_PUT) && scroll) begin
            state_next = ST_COPY;
          end else if ((cmd.func == FUNC_READ) && read_ok) begin
            state_next = ST_READ;
          end else if (cmd.func == FUNC_CLEAR) begin
            state_next = ST_FILL;
          end
        end
      end
      ST_READ: begin
        state_next = ST_IDLE;
      end
      ST_COPY: begin
        if (ptr == COPY_LAST) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FILL;
      end
      ST_FILL: begin
        if (ptr == LAST_CELL) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  always_comb begin
    ram             = '0;
    ptr_next        = ptr;
    cmd_ready       = 1'b0;
    res_load        = 1'b0;
    res.cell_value  = '0;
    res.cursor_row  = cur_row_next;
    res.cursor_col  = cur_col_next;
    case (state)
      ST_INIT: begin
        ram.we    = 1'b1;
        ram.waddr = ptr;
        ram.wdata = {RESET_COLOR, BLANK_CHAR};
        ptr_next  = (ptr == LAST_CELL) ? '0 : ptr + ADDR_W'(1);
      end
      ST_IDLE: begin
        cmd_ready = out_free;
        ptr_next  = '0;
        if (accept) begin
          case (cmd.func)
            FUNC_PUT: begin
              ram.we    = !newline;
              ram.waddr = cur_addr;
              ram.wdata = put_word;
              res_load  = !scroll;
            end
            FUNC_READ: begin
              ram.re    = read_ok;
              ram.raddr = read_addr;
              res_load  = !read_ok;
            end
            FUNC_CLEAR: begin
              res_load = 1'b0;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        res_load       = 1'b1;
        res.cell_value = rdata;
      end
      ST_COPY: begin
        ram.re    = 1'b1;
        ram.raddr = ptr + ROW_STRIDE;
        ram.we    = pend;
        ram.waddr = hold_addr;
        ram.wdata = rdata;
        ptr_next  = ptr + ADDR_W'(1);
      end
      ST_DRAIN: begin
        ram.we    = 1'b1;
        ram.waddr = hold_addr;
        ram.wdata = rdata;
        ptr_next  = FILL_FIRST;
      end
      ST_FILL: begin
        ram.we    = 1'b1;
        ram.waddr = ptr;
        ram.wdata = blank_word;
        ptr_next  = ptr + ADDR_W'(1);
        res_load  = (ptr == LAST_CELL);
      end
      default: begin
        ptr_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_INIT;
      ptr     <= '0;
      pend    <= 1'b0;
      cur_row <= '0;
      cur_col <= '0;
    end else begin
      state   <= state_next;
      ptr     <= ptr_next;
      pend    <= (state == ST_COPY);
      cur_row <= cur_row_next;
      cur_col <= cur_col_next;
    end
  end

  always_ff @(posedge clk) begin
    hold_addr <= ptr;
  end

endmodule

`default_nettype wire

/* sv/tcw_checker.sv */
// Port-level checker for the text console writer, bound to the top level.
`default_nettype none
`include "text_console_writer_assert.svh"

module tcw_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [23:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  import tcw_pkg::*;

  `TCW_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")
  `TCW_ASSERT_SAME(a_col_range, m_axis_tvalid, int'(m_axis_tdata[27:21]) < COLUMNS, "cursor column out of range")
  `TCW_ASSERT_SAME(a_row_range, m_axis_tvalid, int'(m_axis_tdata[20:16]) < ROWS, "cursor row out of range")
  `TCW_ASSERT_NEXT(a_color_rb, psel && penable && pwrite && pready && (paddr[2] == REG_TEXT_COLOR), (paddr[2] != REG_TEXT_COLOR) || (prdata[7:0] == $past(pwdata[7:0])), "colour register readback mismatch")

endmodule

bind text_console_writer tcw_port_checker u_tcw_checker (.*);

`default_nettype wire
